// ===== rtl/ncc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ncc_pkg;

    // Field widths
    localparam int ChanW = 16;
    localparam int IrW = 12;
    localparam int HueW = 8;
    // Channel * 255 fits in 24 bits; one divider cell per dividend bit
    localparam int DivW = 24;
    localparam int NumCells = DivW;
    localparam int NumLanes = 3;
    localparam int CfgIdxW = 3;

    // Lane order inside a divider stage
    localparam int LaneRed = 0;
    localparam int LaneGreen = 1;
    localparam int LaneBlue = 2;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_BLACK_CLEAR_HIGH = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_WHITE_CLEAR_LOW = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_SILVER_CLEAR_LOW = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_CLEAR_MARGIN = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_HUE_MARGIN = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_INFRARED_LIMIT = 3'd5;

    // Class codes, pin encoding
    typedef enum logic [2:0] {
        CLS_WHITE = 3'd0,
        CLS_BLUE = 3'd1,
        CLS_SILVER = 3'd2,
        CLS_BLACK = 3'd3,
        CLS_RED = 3'd4,
        CLS_GREEN = 3'd5,
        CLS_UNKNOWN = 3'd6
    } ncc_color_t;

    // One division lane: dividend bits shift out at the top while quotient
    // bits shift in at the bottom; rem is the partial remainder
    typedef struct packed {
        logic [DivW-1:0] word;
        logic [ChanW-1:0] rem;
    } ncc_lane_t;

    // Payload carried from cell to cell
    typedef struct packed {
        ncc_lane_t [NumLanes-1:0] lane;
        logic [ChanW-1:0] clear;
        logic [IrW-1:0] infrared;
    } ncc_stage_t;

    // Calibrated bounds
    typedef struct packed {
        logic [ChanW-1:0] black_clear_high;
        logic [ChanW-1:0] white_clear_low;
        logic [ChanW-1:0] silver_clear_low;
        logic [ChanW-1:0] clear_margin;
        logic [HueW-1:0] hue_margin;
        logic [IrW-1:0] infrared_limit;
    } ncc_cfg_t;

    // Classifier result
    typedef struct packed {
        ncc_color_t color;
        logic black;
        logic [ChanW-1:0] red;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] blue;
    } ncc_result_t;

endpackage

`default_nettype wire

// ===== rtl/normalized_color_classifier_unit.sv =====
// A result is presented once its request has been accepted and has passed
// through 24 divider cells, one quotient bit each, then the classifier register.
// Throughput: one request per cycle when not stalled; the cell chain sets this.
// Output stall freezes the whole chain until the result is taken.
// Reset (rst_n low, asynchronous) empties the chain and loads the default bounds.
`timescale 1ns / 1ps
`default_nettype none

module normalized_color_classifier_unit
    import ncc_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    output logic in_stall,
    input wire logic [15:0] red_raw,
    input wire logic [15:0] green_raw,
    input wire logic [15:0] blue_raw,
    input wire logic [15:0] clear_raw,
    input wire logic [11:0] infrared_level,
    output logic out_valid,
    input wire logic out_stall,
    output logic [2:0] color_code,
    output logic black_alert,
    output logic [15:0] red_scaled,
    output logic [15:0] green_scaled,
    output logic [15:0] blue_scaled,
    input wire logic cfg_valid,
    output logic cfg_ready,
    input wire logic [2:0] cfg_index,
    input wire logic [15:0] cfg_data
);

    ncc_cfg_t cfg_reg;
    ncc_stage_t entry_data;
    ncc_stage_t stage_data [NumCells+1];
    logic [NumCells:0] stage_valid;
    ncc_result_t result;
    ncc_result_t result_reg;
    logic out_valid_reg;
    logic advance;

    // Move the chain unless a finished result is held back
    assign advance = !(out_valid_reg && out_stall);
    assign in_stall = !advance;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.black_clear_high <= 16'd425;
            cfg_reg.white_clear_low <= 16'd4557;
            cfg_reg.silver_clear_low <= 16'd4753;
            cfg_reg.clear_margin <= 16'd200;
            cfg_reg.hue_margin <= 8'd13;
            cfg_reg.infrared_limit <= 12'd72;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BLACK_CLEAR_HIGH: cfg_reg.black_clear_high <= cfg_data;
                CFG_WHITE_CLEAR_LOW: cfg_reg.white_clear_low <= cfg_data;
                CFG_SILVER_CLEAR_LOW: cfg_reg.silver_clear_low <= cfg_data;
                CFG_CLEAR_MARGIN: cfg_reg.clear_margin <= cfg_data;
                CFG_HUE_MARGIN: cfg_reg.hue_margin <= cfg_data[HueW-1:0];
                CFG_INFRARED_LIMIT: cfg_reg.infrared_limit <= cfg_data[IrW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Form the dividends: channel * 255 as (channel << 8) - channel
    always_comb
    begin
        entry_data.lane[LaneRed].word = {red_raw, 8'd0} - {8'd0, red_raw};
        entry_data.lane[LaneGreen].word = {green_raw, 8'd0} - {8'd0, green_raw};
        entry_data.lane[LaneBlue].word = {blue_raw, 8'd0} - {8'd0, blue_raw};
        for (int i = 0; i < NumLanes; i++)
        begin
            entry_data.lane[i].rem = '0;
        end
        entry_data.clear = clear_raw;
        entry_data.infrared = infrared_level;
    end
    assign stage_data[0] = entry_data;
    assign stage_valid[0] = in_valid;

    // Chain of divider cells
    for (genvar k = 0; k < NumCells; k++)
    begin : g_cell
        ncc_div_cell u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .advance(advance),
            .valid_in(stage_valid[k]),
            .data_in(stage_data[k]),
            .valid_reg(stage_valid[k+1]),
            .data_reg(stage_data[k+1])
        );
    end

    ncc_classify u_classify (
        .data_in(stage_data[NumCells]),
        .cfg(cfg_reg),
        .result(result)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= stage_valid[NumCells];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign color_code = result_reg.color;
    assign black_alert = result_reg.black;
    assign red_scaled = result_reg.red;
    assign green_scaled = result_reg.green;
    assign blue_scaled = result_reg.blue;

    // Alert flag agrees with the class code
    a_black_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (black_alert == (color_code == CLS_BLACK)))
        else $error("black_alert disagrees with color_code");

    // An empty output never holds back the input
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    // Zero clear gives zero scaled channels
    a_zero_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid[NumCells] && advance && (stage_data[NumCells].clear == '0))
        |=> (out_valid && (red_scaled == '0) && (green_scaled == '0)
             && (blue_scaled == '0)))
        else $error("scaled channels not zero for zero clear");

    // An accepted request enters the first cell
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> stage_valid[1])
        else $error("accepted request lost at chain entry");

endmodule

`default_nettype wire

// ===== rtl/ncc_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ncc_div_cell
    import ncc_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic advance,
    input wire logic valid_in,
    input wire ncc_stage_t data_in,
    output logic valid_reg,
    output ncc_stage_t data_reg
);

    ncc_stage_t data_next;

    // Retire one quotient bit per lane: shift, trial subtract, restore
    always_comb
    begin
        data_next = data_in;
        for (int i = 0; i < NumLanes; i++)
        begin
            logic [ChanW:0] shifted;
            logic ge;
            shifted = {data_in.lane[i].rem, data_in.lane[i].word[DivW-1]};
            ge = (shifted >= {1'b0, data_in.clear});
            if (ge)
            begin
                data_next.lane[i].rem = ChanW'(shifted - {1'b0, data_in.clear});
            end
            else
            begin
                data_next.lane[i].rem = shifted[ChanW-1:0];
            end
            data_next.lane[i].word = {data_in.lane[i].word[DivW-2:0], ge};
        end
    end

    // Hold the request flag while the chain is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    // Advance the payload with the chain
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ncc_classify.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ncc_classify
    import ncc_pkg::*;
(
    input wire ncc_stage_t data_in,
    input wire ncc_cfg_t cfg,
    output ncc_result_t result
);

    logic [ChanW-1:0] red_q;
    logic [ChanW-1:0] green_q;
    logic [ChanW-1:0] blue_q;
    logic signed [ChanW:0] hue_lim;
    logic signed [ChanW:0] b_r;
    logic signed [ChanW:0] b_g;
    logic signed [ChanW:0] r_g;
    logic signed [ChanW:0] r_b;
    logic signed [ChanW:0] g_r;
    logic signed [ChanW:0] g_b;
    logic [ChanW:0] clear_ext;
    logic [ChanW:0] clear_plus_margin;
    logic [ChanW:0] black_bound;
    logic is_black;
    logic is_blue;
    logic is_red;
    logic is_green;
    logic is_silver;
    logic is_white;

    // Force zero quotients when clear is zero; keep the low 16 bits
    always_comb
    begin
        if (data_in.clear == '0)
        begin
            red_q = '0;
            green_q = '0;
            blue_q = '0;
        end
        else
        begin
            red_q = data_in.lane[LaneRed].word[ChanW-1:0];
            green_q = data_in.lane[LaneGreen].word[ChanW-1:0];
            blue_q = data_in.lane[LaneBlue].word[ChanW-1:0];
        end
    end

    // Signed channel differences
    assign hue_lim = $signed({{(ChanW + 1 - HueW){1'b0}}, cfg.hue_margin});
    assign b_r = $signed({1'b0, blue_q}) - $signed({1'b0, red_q});
    assign b_g = $signed({1'b0, blue_q}) - $signed({1'b0, green_q});
    assign r_g = $signed({1'b0, red_q}) - $signed({1'b0, green_q});
    assign r_b = $signed({1'b0, red_q}) - $signed({1'b0, blue_q});
    assign g_r = $signed({1'b0, green_q}) - $signed({1'b0, red_q});
    assign g_b = $signed({1'b0, green_q}) - $signed({1'b0, blue_q});

    // Clear bounds; c > low - margin is taken as c + margin > low
    assign clear_ext = {1'b0, data_in.clear};
    assign clear_plus_margin = clear_ext + {1'b0, cfg.clear_margin};
    assign black_bound = {1'b0, cfg.black_clear_high} + {1'b0, cfg.clear_margin};

    assign is_black = (clear_ext < black_bound);
    assign is_blue = (b_r > hue_lim) && (b_g > hue_lim);
    assign is_red = (r_g > hue_lim) && (r_b > hue_lim);
    assign is_green = (g_r > hue_lim) && (g_b > hue_lim);
    assign is_silver = (data_in.infrared < cfg.infrared_limit)
                       && (clear_plus_margin > {1'b0, cfg.silver_clear_low});
    assign is_white = (clear_plus_margin > {1'b0, cfg.white_clear_low});

    // Pick the class in priority order
    always_comb
    begin
        if (is_black)
        begin
            result.color = CLS_BLACK;
        end
        else if (is_blue)
        begin
            result.color = CLS_BLUE;
        end
        else if (is_red)
        begin
            result.color = CLS_RED;
        end
        else if (is_green)
        begin
            result.color = CLS_GREEN;
        end
        else if (is_silver)
        begin
            result.color = CLS_SILVER;
        end
        else if (is_white)
        begin
            result.color = CLS_WHITE;
        end
        else
        begin
            result.color = CLS_UNKNOWN;
        end
        result.black = is_black;
        result.red = red_q;
        result.green = green_q;
        result.blue = blue_q;
    end

endmodule

`default_nettype wire
